FILE: hw/rtl/mpskd_pkg.sv
// ----------------------------------------------------------------------------
// mpskd_pkg
// Shared types and constants of the M-PSK phase demapper: the arctangent
// table of the vectoring rotation and the fixed field widths.
// ----------------------------------------------------------------------------
package mpskd_pkg;

  // Widths of the stream fields, fixed by the interface.
  localparam int FIELD_W   = 16;
  localparam int SYMBOL_W  = 6;
  localparam int BPS_W     = 3;
  localparam int ANGLE_W   = 32;

  // Reset value of the bits-per-symbol register (8-PSK).
  localparam logic [BPS_W-1:0] BPS_RESET = 3'd3;

  // Half a turn in the 32-bit angle format.
  localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

  // Number of entries held in the arctangent table.
  localparam int ATAN_ENTRIES = 24;

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32 and rounded.
  localparam logic [ANGLE_W-1:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
    32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
  };

endpackage

FILE: hw/rtl/mpsk_phase_demapper.sv
// ----------------------------------------------------------------------------
// mpsk_phase_demapper
// Hard-decision M-PSK demodulator: a vectoring CORDIC chain finds the phase
// of each received sample and a slicer returns the index of its sector.
// ----------------------------------------------------------------------------
// Usage notes.
// Input items arrive on the s_axis channel: tdata carries in_phase in bits
// [15:0] and quadrature in bits [31:16], both two's complement. Each item
// yields exactly one output item on m_axis, whose tdata carries the symbol
// index in bits [5:0] (upper bits zero). Items leave in the order they came.
// The constellation size M = 2^bits_per_symbol is set through cfg_we and
// cfg_wdata; write it only while no item is in flight.
// From acceptance to m_axis_tvalid an item passes one fold cell, one cell
// per micro-rotation, one rounding stage and the output register.
// Throughput is one item per clock while the receiver takes results; every
// cell of the chain is a register stage with its own valid and ready, so a
// new item enters while older ones are still being rotated.
// Reset empties the chain (all valid flags cleared) and sets
// bits_per_symbol to 3. When the receiver stalls, the result waits in the
// output register and upstream items keep moving until empty cells fill up;
// only then is s_axis_tready lowered.
// ----------------------------------------------------------------------------
module mpsk_phase_demapper
  import mpskd_pkg::*;
#(
  parameter int SAMPLE_BITS         = 16,
  parameter int PHASE_BITS          = 16,
  parameter int CORDIC_STAGES       = 16,
  parameter int MAX_BITS_PER_SYMBOL = 6
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration: bits_per_symbol.
  input  logic               cfg_we,
  input  logic [BPS_W-1:0]   cfg_wdata,
  // Sample input.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,   // [15:0] in_phase, [31:16] quadrature
  // Symbol output.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata    // [5:0] symbol, [7:6] zero
);

  // Two guard bits cover the half-turn fold of the most negative sample and
  // the CORDIC gain of about 1.65.
  localparam int W     = SAMPLE_BITS + 2;
  // The rotation chain cannot be longer than the arctangent table.
  localparam int NSTG  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  logic [BPS_W-1:0] bits_per_symbol;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_symbol <= BPS_RESET;
    end else if (cfg_we) begin
      bits_per_symbol <= cfg_wdata;
    end
  end

  // Links between the cells: index 0 is the fold cell output, index n the
  // output of micro-rotation n-1.
  logic                  lnk_valid [NSTG+1];
  logic                  lnk_ready [NSTG+1];
  logic signed [W-1:0]   lnk_x     [NSTG+1];
  logic signed [W-1:0]   lnk_y     [NSTG+1];
  logic [ANGLE_W-1:0]    lnk_z     [NSTG+1];
  logic                  lnk_zero  [NSTG+1];

  logic [SYMBOL_W-1:0]   symbol;

  mpskd_prerotate #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .W           (W)
  ) u_fold (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_i      (s_axis_tdata[FIELD_W-1:0]),
    .in_q      (s_axis_tdata[2*FIELD_W-1:FIELD_W]),
    .out_valid (lnk_valid[0]),
    .out_ready (lnk_ready[0]),
    .out_x     (lnk_x[0]),
    .out_y     (lnk_y[0]),
    .out_z     (lnk_z[0]),
    .out_zero  (lnk_zero[0])
  );

  for (genvar g = 0; g < NSTG; g++) begin : g_cell
    mpskd_cordic_cell #(
      .W     (W),
      .STAGE (g)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (lnk_valid[g]),
      .in_ready  (lnk_ready[g]),
      .in_x      (lnk_x[g]),
      .in_y      (lnk_y[g]),
      .in_z      (lnk_z[g]),
      .in_zero   (lnk_zero[g]),
      .out_valid (lnk_valid[g+1]),
      .out_ready (lnk_ready[g+1]),
      .out_x     (lnk_x[g+1]),
      .out_y     (lnk_y[g+1]),
      .out_z     (lnk_z[g+1]),
      .out_zero  (lnk_zero[g+1])
    );
  end

  // The residual x and y of the last cell are not needed by the slicer.
  mpskd_slicer #(
    .PHASE_BITS          (PHASE_BITS),
    .MAX_BITS_PER_SYMBOL (MAX_BITS_PER_SYMBOL)
  ) u_slicer (
    .clk             (clk),
    .rst             (rst),
    .bits_per_symbol (bits_per_symbol),
    .in_valid        (lnk_valid[NSTG]),
    .in_ready        (lnk_ready[NSTG]),
    .in_z            (lnk_z[NSTG]),
    .in_zero         (lnk_zero[NSTG]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .out_symbol      (symbol)
  );

  assign m_axis_tdata = 8'(symbol);

endmodule

FILE: hw/rtl/mpskd_prerotate.sv
// ----------------------------------------------------------------------------
// mpskd_prerotate
// Entry cell: sign-extends the sample, folds the left half plane onto the
// right one by a half-turn rotation and flags the zero vector.
// ----------------------------------------------------------------------------
module mpskd_prerotate
  import mpskd_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int W           = 18
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [FIELD_W-1:0]        in_i,
  input  logic [FIELD_W-1:0]        in_q,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [W-1:0]       out_x,
  output logic signed [W-1:0]       out_y,
  output logic [ANGLE_W-1:0]        out_z,
  output logic                      out_zero
);

  localparam int RAW_W = (SAMPLE_BITS > FIELD_W) ? SAMPLE_BITS : FIELD_W;

  logic [RAW_W-1:0]             raw_i;
  logic [RAW_W-1:0]             raw_q;
  logic signed [SAMPLE_BITS-1:0] smp_i;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic signed [W-1:0]          ext_i;
  logic signed [W-1:0]          ext_q;
  logic signed [W-1:0]          x_next;
  logic signed [W-1:0]          y_next;
  logic [ANGLE_W-1:0]           z_next;
  logic                         zero_next;

  // Only the low SAMPLE_BITS bits of each field carry the sample.
  always_comb begin
    raw_i     = RAW_W'(in_i);
    raw_q     = RAW_W'(in_q);
    smp_i     = signed'(raw_i[SAMPLE_BITS-1:0]);
    smp_q     = signed'(raw_q[SAMPLE_BITS-1:0]);
    ext_i     = W'(smp_i);
    ext_q     = W'(smp_q);
    zero_next = (ext_i == '0) && (ext_q == '0);
    if (ext_i[W-1]) begin
      x_next = -ext_i;
      y_next = -ext_q;
      z_next = HALF_TURN;
    end else begin
      x_next = ext_i;
      y_next = ext_q;
      z_next = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_zero <= zero_next;
    end
  end

endmodule

FILE: hw/rtl/mpskd_cordic_cell.sv
// ----------------------------------------------------------------------------
// mpskd_cordic_cell
// One vectoring micro-rotation with a fixed shift, registered, with its
// own valid/ready so that bubbles in the chain can close up.
// ----------------------------------------------------------------------------
module mpskd_cordic_cell
  import mpskd_pkg::*;
#(
  parameter int W     = 18,
  parameter int STAGE = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [W-1:0] in_x,
  input  logic signed [W-1:0] in_y,
  input  logic [ANGLE_W-1:0]  in_z,
  input  logic                in_zero,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [W-1:0] out_x,
  output logic signed [W-1:0] out_y,
  output logic [ANGLE_W-1:0]  out_z,
  output logic                out_zero
);

  localparam logic [ANGLE_W-1:0] ATAN_STEP = ATAN_TURN32[STAGE];

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic signed [W-1:0] x_next;
  logic signed [W-1:0] y_next;
  logic [ANGLE_W-1:0]  z_next;

  // Arithmetic shifts round towards minus infinity.
  always_comb begin
    xs = in_x >>> STAGE;
    ys = in_y >>> STAGE;
    if (!in_y[W-1]) begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + ATAN_STEP;
    end else begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - ATAN_STEP;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_zero <= in_zero;
    end
  end

endmodule

FILE: hw/rtl/mpskd_slicer.sv
// ----------------------------------------------------------------------------
// mpskd_slicer
// Rounds the angle to PHASE_BITS per turn, then picks the phase sector of
// the constellation in a second registered stage that drives the output.
// ----------------------------------------------------------------------------
module mpskd_slicer
  import mpskd_pkg::*;
#(
  parameter int PHASE_BITS          = 16,
  parameter int MAX_BITS_PER_SYMBOL = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [BPS_W-1:0]     bits_per_symbol,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ANGLE_W-1:0]   in_z,
  input  logic                 in_zero,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SYMBOL_W-1:0]  out_symbol
);

  localparam int CAP    = (MAX_BITS_PER_SYMBOL < PHASE_BITS) ? MAX_BITS_PER_SYMBOL
                                                              : PHASE_BITS;
  localparam int QW     = PHASE_BITS + 1;
  localparam int SH_W   = $clog2(QW + 1);
  localparam logic [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(1) << (ANGLE_W - 1 - PHASE_BITS);

  // Stage one: rounded phase.
  logic                   ph_valid;
  logic                   ph_ready;
  logic [PHASE_BITS-1:0]  phase;
  logic                   ph_zero;
  logic [ANGLE_W-1:0]     z_round;

  // Stage two: sector decision.
  logic [BPS_W-1:0]       b_eff;
  logic [SH_W-1:0]        sh;
  logic [QW-1:0]          q;
  logic [QW-1:0]          h2;
  logic [QW-1:0]          m;
  logic [QW-1:0]          k;
  logic [SYMBOL_W-1:0]    symbol_next;

  assign z_round  = in_z + ROUND_HALF;
  assign in_ready = !ph_valid || ph_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph_valid <= 1'b0;
    end else if (in_ready) begin
      ph_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      phase   <= z_round[ANGLE_W-1 -: PHASE_BITS];
      ph_zero <= in_zero;
    end
  end

  // Sector k covers (k-1/2)S < phase <= (k+1/2)S; the top half sector wraps
  // back to symbol 0.
  always_comb begin
    if (int'(bits_per_symbol) > CAP) begin
      b_eff = BPS_W'(CAP);
    end else begin
      b_eff = bits_per_symbol;
    end
    sh          = SH_W'(PHASE_BITS) - SH_W'(b_eff);
    q           = {phase, 1'b0};
    h2          = QW'(1) << sh;
    m           = QW'(1) << b_eff;
    k           = ((q - h2 - QW'(1)) >> (sh + SH_W'(1))) + QW'(1);
    symbol_next = '0;
    if (!ph_zero && (q > h2) && (k < m)) begin
      symbol_next = SYMBOL_W'(k);
    end
  end

  assign ph_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ph_ready) begin
      out_valid <= ph_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ph_ready && ph_valid) begin
      out_symbol <= symbol_next;
    end
  end

endmodule

FILE: sim/mpsk_phase_demapper_tb.sv
// ----------------------------------------------------------------------------
// mpsk_phase_demapper_tb
// Self-checking bench for the M-PSK phase demapper. Samples are streamed in
// with bursty valid and a stalling receiver; each output item is compared
// with a symbol from the directed table or from an independent model of the
// vectoring rotation and sector slicer, under every constellation size setting.
// ----------------------------------------------------------------------------
module mpsk_phase_demapper_tb;
  import mpskd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Block configuration as instantiated (the defaults of the top level).
  localparam int STAGES       = 16;
  localparam int PHASE_W      = 16;
  localparam int MAX_BPS      = 6;
  // Acceptance to output valid, from the registers of the top-level chain.
  localparam int LATENCY      = STAGES + 3;
  // How long the receiver holds off during the back-pressure test.
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 75;

  // atan(2^-s) as a fraction of a turn, scaled by 2^32 and rounded to nearest.
  localparam logic [31:0] ROTATION_ANGLE [STAGES] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
    32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
    32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D
  };

  // One row of the directed part. Where known is set, symbol is the answer
  // for the reset setting of 8-PSK; otherwise the model decides.
  typedef struct packed {
    logic signed [FIELD_W-1:0] i_comp;
    logic signed [FIELD_W-1:0] q_comp;
    bit                        known;
    logic [SYMBOL_W-1:0]       symbol;
  } probe_t;

  localparam int NUM_PROBES = 23;

  localparam probe_t PROBES [NUM_PROBES] = '{
    // The zero vector always decides symbol 0.
    '{16'sd0,      16'sd0,      1'b1, 6'd0},
    // Full-scale points on the axes and the diagonals, sector centres at 8-PSK.
    '{16'sh7FFF,   16'sd0,      1'b1, 6'd0},
    '{16'sd0,      16'sh7FFF,   1'b1, 6'd2},
    '{16'sh8000,   16'sd0,      1'b1, 6'd4},
    '{16'sd0,      16'sh8000,   1'b1, 6'd6},
    '{16'sh7FFF,   16'sh7FFF,   1'b1, 6'd1},
    '{16'sh8000,   16'sh7FFF,   1'b1, 6'd3},
    '{16'sh8000,   16'sh8000,   1'b1, 6'd5},
    '{16'sh7FFF,   16'sh8000,   1'b1, 6'd7},
    '{16'sd1,      16'sd0,      1'b1, 6'd0},
    // Vectors of one or two LSBs, where the rotation is at its coarsest.
    '{16'sd0,      16'sd1,      1'b0, 6'd0},
    '{-16'sd1,     16'sd0,      1'b0, 6'd0},
    '{16'sd0,      -16'sd1,     1'b0, 6'd0},
    '{-16'sd1,     -16'sd1,     1'b0, 6'd0},
    '{16'sd1,      -16'sd1,     1'b0, 6'd0},
    '{16'sd1,      16'sd1,      1'b0, 6'd0},
    '{-16'sd1,     16'sd1,      1'b0, 6'd0},
    // Just either side of the negative real axis, where the half-turn fold
    // meets the wrap of the angle, and just below the positive real axis.
    '{16'sh8000,   16'sd1,      1'b0, 6'd0},
    '{16'sh8000,   -16'sd1,     1'b0, 6'd0},
    '{16'sh7FFF,   -16'sd1,     1'b0, 6'd0},
    // Close to the 8-PSK sector boundaries at 22.5, 67.5 and 112.5 degrees.
    '{16'sd30274,  16'sd12540,  1'b0, 6'd0},
    '{16'sd12540,  16'sd30274,  1'b0, 6'd0},
    '{-16'sd12540, 16'sd30274,  1'b0, 6'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [BPS_W-1:0]       cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [2*FIELD_W-1:0]   s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;

  // Symbols still owed by the block, oldest first.
  logic [SYMBOL_W-1:0]    pending_symbols [$];
  // The setting the block holds, as far as the bench knows.
  logic [BPS_W-1:0]       active_bps = BPS_RESET;
  int                     mismatch_count = 0;
  // Sender burst bookkeeping.
  int                     burst_left = 0;
  // Raised by the stimulus to ask the receiver for a long hold-off.
  bit                     hold_request = 1'b0;
  int                     hold_left = 0;
  int unsigned            rx_cycle = 0;

  mpsk_phase_demapper u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Works out the decided symbol for one sample. The vector is folded into
  // the right half-plane, rotated towards the real axis while the angle
  // accumulates in 32-bit turns, rounded to PHASE_W bits and then sliced.
  function automatic logic [SYMBOL_W-1:0] decide_symbol(
    input logic signed [FIELD_W-1:0] i_comp,
    input logic signed [FIELD_W-1:0] q_comp,
    input logic [BPS_W-1:0]          bps
  );
    longint            x;
    longint            y;
    longint            x_sh;
    longint            y_sh;
    logic [31:0]       angle;
    longint unsigned   angle_wide;
    longint unsigned   phase;
    longint unsigned   twice;
    longint unsigned   half_sector;
    longint unsigned   k;
    int                b;
    int                s;
    x = longint'(i_comp);
    y = longint'(q_comp);
    if (x == 0 && y == 0) begin
      return '0;
    end
    angle = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      angle = 32'h8000_0000;
    end
    for (s = 0; s < STAGES; s++) begin
      // Arithmetic shifts round towards minus infinity, as the hardware does.
      x_sh = x >>> s;
      y_sh = y >>> s;
      if (y >= 0) begin
        x = x + y_sh;
        y = y - x_sh;
        angle = angle + ROTATION_ANGLE[s];
      end else begin
        x = x - y_sh;
        y = y + x_sh;
        angle = angle - ROTATION_ANGLE[s];
      end
    end
    angle_wide = 64'(angle);
    phase = ((angle_wide + (64'd1 << (31 - PHASE_W))) >> (32 - PHASE_W))
            & ((64'd1 << PHASE_W) - 1);
    // Settings above the supported maximum behave as the maximum.
    b = int'(bps);
    if (b > MAX_BPS) begin
      b = MAX_BPS;
    end
    // Work in half-sector units so that the boundaries are whole numbers.
    twice = phase << 1;
    half_sector = 64'd1 << (PHASE_W - b);
    if (twice <= half_sector) begin
      return '0;
    end
    k = ((twice - half_sector - 1) >> (PHASE_W - b + 1)) + 1;
    if (k >= (64'd1 << b)) begin
      return '0;
    end
    return k[SYMBOL_W-1:0];
  endfunction

  // Offers one sample and waits for it to be taken. The expected symbol is
  // either the one given or the model's, under the current setting.
  task automatic push_sample(
    input logic signed [FIELD_W-1:0] i_comp,
    input logic signed [FIELD_W-1:0] q_comp,
    input bit                        given,
    input logic [SYMBOL_W-1:0]       given_symbol
  );
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {q_comp, i_comp};
    do @(posedge clk); while (!s_axis_tready);
    if (given) begin
      pending_symbols.push_back(given_symbol);
    end else begin
      pending_symbols.push_back(decide_symbol(i_comp, q_comp, active_bps));
    end
  endtask

  // Sends one sample as part of a burst. When a burst runs out, valid is
  // dropped for a random gap (possibly none) before the next one starts.
  task automatic issue_sample(
    input logic signed [FIELD_W-1:0] i_comp,
    input logic signed [FIELD_W-1:0] q_comp,
    input bit                        back_to_back,
    input bit                        given,
    input logic [SYMBOL_W-1:0]       given_symbol
  );
    int gap;
    if (!back_to_back && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    push_sample(i_comp, q_comp, given, given_symbol);
    if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Stops offering samples and waits until every owed symbol has come out,
  // then lets the pipeline settle for a while longer.
  task automatic drain_pipeline();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_symbols.size() != 0);
    repeat (2 * LATENCY) @(posedge clk);
  endtask

  task automatic write_bps(input logic [BPS_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    active_bps = value;
    cfg_we    <= 1'b0;
  endtask

  // Zero or one of the two full-scale rails.
  function automatic logic signed [FIELD_W-1:0] rail_value();
    case ($urandom_range(0, 2))
      0:       return 16'sd0;
      1:       return 16'sh7FFF;
      default: return 16'sh8000;
    endcase
  endfunction

  // Random samples: mostly full-range, with a share of rail and axis points
  // and of tiny vectors, where the rotation is least exact.
  task automatic run_random(input int count, input bit back_to_back);
    logic signed [FIELD_W-1:0] i_comp;
    logic signed [FIELD_W-1:0] q_comp;
    int                        n;
    for (n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0: begin
          i_comp = rail_value();
          q_comp = rail_value();
        end
        1, 2: begin
          i_comp = FIELD_W'($urandom_range(0, 8) - 4);
          q_comp = FIELD_W'($urandom_range(0, 8) - 4);
        end
        default: begin
          i_comp = FIELD_W'($urandom);
          q_comp = FIELD_W'($urandom);
        end
      endcase
      issue_sample(i_comp, q_comp, back_to_back, 1'b0, '0);
    end
  endtask

  // Receiver: it takes results on a pattern picked by bits [8:7] of rx_cycle
  // (always ready, coin toss, ready a quarter of the time, mostly ready), and
  // on request holds off completely while hold_left counts down. Results are
  // checked here against the oldest owed symbol.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_symbols.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: symbol %0d arrived with none owed", $realtime, m_axis_tdata);
          end
        end else begin
          if (m_axis_tdata !== {2'b00, pending_symbols[0]}) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: symbol mismatch, expected %0d, got %0d (tdata %h)",
                       $realtime, pending_symbols[0], m_axis_tdata[5:0], m_axis_tdata);
            end
          end
          void'(pending_symbols.pop_front());
        end
      end
      rx_cycle <= rx_cycle + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_cycle[8:7])
          2'd0:    m_axis_tready <= 1'b1;
          2'd1:    m_axis_tready <= 1'($urandom_range(0, 1));
          2'd2:    m_axis_tready <= (rx_cycle[1:0] == 2'd0);
          default: m_axis_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // Main stimulus.
  initial begin
    int          p;
    int          r;
    int          bps_plan [8];
    bps_plan = '{0, 1, 2, 7, 6, 4, 5, 3};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset setting of 8-PSK.
    for (r = 0; r < NUM_PROBES; r++) begin
      issue_sample(PROBES[r].i_comp, PROBES[r].q_comp, 1'b0,
                   PROBES[r].known, PROBES[r].symbol);
    end

    // Random part, one block per setting. The setting of zero (a single
    // symbol), the setting of seven (clamped to 64-PSK) and the extremes in
    // between are all visited. Every block starts from an empty pipeline.
    for (p = 0; p < 8; p++) begin
      drain_pipeline();
      write_bps(BPS_W'(bps_plan[p]));
      if (p == 2) begin
        // Back-pressure test: the receiver holds off while samples keep
        // coming back to back, so the chain fills and the input stalls.
        hold_request = 1'b1;
        run_random(48, 1'b1);
        run_random(RANDOM_ITEMS - 48, 1'b0);
      end else begin
        run_random(RANDOM_ITEMS, 1'b0);
      end
    end

    drain_pipeline();
    if (mismatch_count == 0 && pending_symbols.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("%0t: timed out with %0d symbols owed", $realtime, pending_symbols.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/mpskd_pkg.sv
hw/rtl/mpskd_prerotate.sv
hw/rtl/mpskd_cordic_cell.sv
hw/rtl/mpskd_slicer.sv
hw/rtl/mpsk_phase_demapper.sv
sim/mpsk_phase_demapper_tb.sv
